// ----- rtl/hsp_pkg.sv -----
package hsp_pkg;

	localparam int unsigned CompW = 8;
	localparam int unsigned HueW = 17;
	localparam int unsigned SatW = 17;
	localparam int unsigned BriW = 16;
	// Radicand width: the weights sum to 2^16, so the sum stays below 2^32.
	localparam int unsigned SumW = 32;
	// Quotient bits for n/d and (max-min)/max, both Q0.16 with a possible 1.0.
	localparam int unsigned QuoW = 17;
	localparam int unsigned DefDiv = QuoW;
	localparam int unsigned DefSqrt = BriW;

	localparam logic [15:0] WRed = 16'd19595;
	localparam logic [15:0] WGreen = 16'd38470;
	localparam logic [15:0] WBlue = 16'd7471;

	typedef struct packed {
		logic [SumW-1:0] rem;
		logic [BriW-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic [CompW:0] rem;
		logic [QuoW-1:0] quo;
		logic [CompW-1:0] den;
	} div_t;

	// Hue side data riding with the division: sextant base, sign, grey flag.
	typedef struct packed {
		logic [2:0] base;
		logic minus;
		logic grey;
	} hctl_t;

endpackage

// ----- rtl/hsp_stream_if.sv -----
interface hsp_stream_if #(
	parameter int unsigned Width = 24
) (
	input logic clk
);
	logic valid;
	logic ready;
	logic [Width-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/hsp_sqrt_cell.sv -----
// One bit of a restoring square root: tries root bit Bit and keeps it if it fits.
module hsp_sqrt_cell #(
	parameter int unsigned Bit = 0
) (
	input logic clk,
	input logic en,
	input hsp_pkg::sqrt_t d,
	output hsp_pkg::sqrt_t q
);
	localparam int unsigned SW = hsp_pkg::SumW;
	logic [SW-1:0] trial;
	hsp_pkg::sqrt_t nxt;

	always_comb begin
		nxt = d;
		trial = (SW'(d.root) << (Bit + 1)) + (SW'(1) << (2 * Bit));
		if (d.rem >= trial) begin
			nxt.rem = d.rem - trial;
			nxt.root[Bit] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

// ----- rtl/hsp_div_cell.sv -----
// One quotient bit of a restoring division by an 8-bit denominator: compare,
// subtract, then double the partial remainder for the next bit.
module hsp_div_cell (
	input logic clk,
	input logic en,
	input hsp_pkg::div_t d,
	output hsp_pkg::div_t q
);
	localparam int unsigned CW = hsp_pkg::CompW;
	localparam int unsigned QW = hsp_pkg::QuoW;
	logic [CW:0] diff;
	hsp_pkg::div_t nxt;

	always_comb begin
		nxt = d;
		diff = d.rem;
		nxt.quo = {d.quo[QW-2:0], 1'b0};
		if (d.rem >= {1'b0, d.den}) begin
			diff = d.rem - {1'b0, d.den};
			nxt.quo[0] = 1'b1;
		end
		// The partial remainder is now below the denominator, so doubling fits.
		nxt.rem = {diff[CW-1:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

// ----- rtl/rgb_to_hsp_converter_unit.sv -----
// Channel  Dir  Handshake    Payload
// in_pix   in   valid/ready  red[7:0], green[7:0], blue[7:0]
// out_hsp  out  valid/ready  hue[16:0], saturation[16:0], brightness[15:0]
//
// One pixel per cycle while the output is not stalled; the depth is set by the
// chain of one-bit division cells. The square root chain runs alongside.
// Reset clears only the stage valid bits. A stall on the output freezes the
// whole chain; an output register holds the finished result, and new input
// enters whenever the last stage is free or being drained.
module rgb_to_hsp_converter_unit (
	input logic clk,
	input logic arst_n,
	hsp_stream_if.sink in_pix,
	hsp_stream_if.source out_hsp
);
	localparam int unsigned DivCells = hsp_pkg::DefDiv;
	localparam int unsigned SqrtCells = hsp_pkg::DefSqrt;
	localparam int unsigned CW = hsp_pkg::CompW;
	localparam int unsigned QW = hsp_pkg::QuoW;
	localparam int unsigned SW = hsp_pkg::SumW;
	localparam int unsigned BW = hsp_pkg::BriW;
	localparam int unsigned HW_C = hsp_pkg::HueW;
	// Stages: s1 squares and sextant, s2 sum, DivCells cells, one output stage.
	localparam int unsigned Depth = DivCells + 3;
	localparam int unsigned SqPad = DivCells - SqrtCells;
	// ceil(2^22 / 6); exact division by six for numerators below 2^19.
	localparam logic [19:0] Recip6 = 20'd699051;

	logic [Depth-1:0] vld_q;
	logic adv;
	logic [CW-1:0] r, g, b;

	assign adv = !vld_q[Depth-1] || out_hsp.ready;
	assign in_pix.ready = adv;
	assign r = in_pix.data[3*CW-1:2*CW];
	assign g = in_pix.data[2*CW-1:CW];
	assign b = in_pix.data[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], in_pix.valid};
		end
	end

	// Stage 1: weighted squares and the sextant decision.
	logic [SW-1:0] wr_s1, wg_s1, wb_s1;
	logic [CW-1:0] hn_s1, hd_s1, sn_s1, sd_s1;
	hsp_pkg::hctl_t hc_s1;
	logic [CW-1:0] mx, mn, hn, hd;
	hsp_pkg::hctl_t hc;

	always_comb begin
		hc = '0;
		hc.grey = (r == g) && (r == b);
		if (r >= g && r >= b) begin
			mx = r;
			if (b >= g) begin
				mn = g; hc.base = 3'd6; hc.minus = 1'b1; hn = b - g; hd = r - g;
			end else begin
				mn = b; hc.base = 3'd0; hn = g - b; hd = r - b;
			end
		end else if (g >= r && g >= b) begin
			mx = g; hc.base = 3'd2;
			if (r >= b) begin
				mn = b; hc.minus = 1'b1; hn = r - b; hd = g - b;
			end else begin
				mn = r; hn = b - r; hd = g - r;
			end
		end else begin
			mx = b; hc.base = 3'd4;
			if (g >= r) begin
				mn = r; hc.minus = 1'b1; hn = g - r; hd = b - r;
			end else begin
				mn = g; hn = r - g; hd = b - g;
			end
		end
		if (hc.grey) begin
			hd = 8'd1;
			mx = 8'd1;
			mn = 8'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wr_s1 <= SW'(r) * SW'(r) * SW'(hsp_pkg::WRed);
			wg_s1 <= SW'(g) * SW'(g) * SW'(hsp_pkg::WGreen);
			wb_s1 <= SW'(b) * SW'(b) * SW'(hsp_pkg::WBlue);
			hn_s1 <= hn;
			hd_s1 <= hd;
			sn_s1 <= mx - mn;
			sd_s1 <= mx;
			hc_s1 <= hc;
		end
	end

	// Stage 2: radicand sum; dividends enter the cell chains.
	hsp_pkg::sqrt_t sq [SqrtCells+1];
	hsp_pkg::div_t hdv [DivCells+1];
	hsp_pkg::div_t sdv [DivCells+1];
	hsp_pkg::hctl_t hcp [DivCells+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			sq[0].rem <= wr_s1 + wg_s1 + wb_s1;
			sq[0].root <= '0;
			hdv[0] <= '{rem: {1'b0, hn_s1}, quo: '0, den: hd_s1};
			sdv[0] <= '{rem: {1'b0, sn_s1}, quo: '0, den: sd_s1};
			hcp[0] <= hc_s1;
		end
	end

	// Each division cell yields one quotient bit, most significant first, so the
	// chain of QW cells gives floor(n*2^16/d) for n <= d.
	for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
		hsp_sqrt_cell #(.Bit(SqrtCells - 1 - i)) u_cell (
			.clk(clk), .en(adv), .d(sq[i]), .q(sq[i+1])
		);
	end

	for (genvar i = 0; i < DivCells; i++) begin : g_div
		hsp_div_cell u_hue (.clk(clk), .en(adv), .d(hdv[i]), .q(hdv[i+1]));
		hsp_div_cell u_sat (.clk(clk), .en(adv), .d(sdv[i]), .q(sdv[i+1]));
		always_ff @(posedge clk) begin
			if (adv) begin
				hcp[i+1] <= hcp[i];
			end
		end
	end

	// Align the root with the longer division chain.
	logic [BW-1:0] rt_q [SqPad+1];
	assign rt_q[0] = sq[SqrtCells].root;
	for (genvar i = 0; i < SqPad; i++) begin : g_pad
		always_ff @(posedge clk) begin
			if (adv) begin
				rt_q[i+1] <= rt_q[i];
			end
		end
	end

	// Final stage: hue = floor((base*2^16*d -+ 2^16*n) / 6d), which equals
	// floor((base*2^16 -+ q) / 6) with q = floor(2^16*n/d) since the terms share d
	// (for minus, a nonzero remainder borrows one more).
	logic [QW+3:0] hnum;
	logic [QW+23:0] hprod;
	logic [QW-1:0] qh;
	logic hrem_nz;
	logic [HW_C-1:0] hue_s;
	logic [HW_C-1:0] hue_q;
	logic [hsp_pkg::SatW-1:0] sat_q;
	logic [BW-1:0] bri_q;

	always_comb begin
		qh = hdv[DivCells].quo;
		hrem_nz = hdv[DivCells].rem != '0;
		if (hcp[DivCells].minus) begin
			// floor((B*2^16*d - 2^16*n)/6d) = floor((B*2^16 - q - [rem!=0])/6)
			hnum = ((QW+4)'(hcp[DivCells].base) << 16) - (QW+4)'(qh)
				- (QW+4)'(hrem_nz);
		end else begin
			hnum = ((QW+4)'(hcp[DivCells].base) << 16) + (QW+4)'(qh);
		end
		// Division by six as a multiply by the scaled reciprocal.
		hprod = (QW+24)'(hnum) * (QW+24)'(Recip6);
		hue_s = hcp[DivCells].grey ? '0 : hprod[22 +: HW_C];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_q <= hue_s;
			sat_q <= hcp[DivCells].grey ? '0 : sdv[DivCells].quo;
			bri_q <= rt_q[SqPad];
		end
	end

	assign out_hsp.valid = vld_q[Depth-1];
	assign out_hsp.data = {hue_q, sat_q, bri_q};

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_hsp.valid && !out_hsp.ready) |-> !in_pix.ready)
		else $error("input taken while the chain is frozen");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_hsp.valid && !out_hsp.ready) |=> out_hsp.valid)
		else $error("result lost under stall");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_hsp.valid |-> out_hsp.data[BW+hsp_pkg::SatW-1:BW] <= 17'd65536)
		else $error("saturation above one");
endmodule
